// ===== sv/rbt_pkg.sv =====
package rbt_pkg;

   typedef enum logic [2:0] {
      OP_INIT    = 3'd0,
      OP_PASS    = 3'd1,
      OP_TOKEN   = 3'd2,
      OP_FITS    = 3'd3,
      OP_RECORD  = 3'd4,
      OP_RELEASE = 3'd5,
      OP_EXHAUST = 3'd6,
      OP_UNUSED  = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      CSR_PASS_LIMIT      = 3'd0,
      CSR_TOKEN_LIMIT     = 3'd1,
      CSR_WORKSPACE_CAP   = 3'd2,
      CSR_WORKSPACE_FLOOR = 3'd3,
      CSR_SIZE_MULTIPLIER = 3'd4,
      CSR_TEXT_LENGTH     = 3'd5
   } csr_index_type;

   localparam logic [15:0] PASS_LIMIT_RESET      = 16'd16;
   localparam logic [31:0] TOKEN_LIMIT_RESET     = 32'd4096;
   localparam logic [31:0] WORKSPACE_CAP_RESET   = 32'd1048576;
   localparam logic [31:0] WORKSPACE_FLOOR_RESET = 32'd4096;
   localparam logic [7:0]  SIZE_MULTIPLIER_RESET = 8'd8;
   localparam logic [31:0] TEXT_LENGTH_RESET     = 32'd0;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] give_bytes;
      logic [31:0] want_bytes;
   } req_word_type;

   typedef struct packed {
      logic        accepted;
      logic [15:0] pass_count;
      logic [31:0] token_count;
      logic [31:0] allocation_count;
      logic [31:0] allocation_total;
      logic [31:0] peak_workspace;
      logic        exhausted;
   } rsp_word_type;

endpackage

// ===== sv/rbt_limit.sv =====
module rbt_limit (
   input  logic        clock,
   input  logic [31:0] text_length,
   input  logic [7:0]  size_multiplier,
   input  logic [31:0] workspace_floor,
   input  logic [31:0] workspace_cap,
   output logic [31:0] limit
);
   import rbt_pkg::*;

   logic [39:0] product;
   logic [31:0] raised;
   logic [31:0] limit_in;
   logic [31:0] limit_ff;

   assign product = 40'(text_length) * 40'(size_multiplier);

   always_comb begin
      raised = (product[31:0] < workspace_floor) ? workspace_floor : product[31:0];
      if (product[39:32] != 8'd0) begin
         limit_in = workspace_cap;
      end else if (raised > workspace_cap) begin
         limit_in = workspace_cap;
      end else begin
         limit_in = raised;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
   end

   assign limit = limit_ff;

endmodule

// ===== sv/rbt_core.sv =====
module rbt_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  rbt_pkg::req_word_type req_word,
   input  logic [15:0]           pass_limit,
   input  logic [31:0]           token_limit,
   input  logic [31:0]           limit_candidate,
   output rbt_pkg::rsp_word_type rsp_word
);
   import rbt_pkg::*;

   logic [15:0] passes_ff, passes_in;
   logic [31:0] tokens_ff, tokens_in;
   logic [31:0] held_ff, held_in;
   logic [31:0] peak_ff, peak_in;
   logic [31:0] allocs_ff, allocs_in;
   logic [31:0] bytes_ff, bytes_in;
   logic        spent_ff, spent_in;
   logic [31:0] limit_ff, limit_in;

   logic        give_over;
   logic [31:0] retained;
   logic [31:0] room;
   logic        fits;
   logic [31:0] held_alloc;
   logic [32:0] bytes_sum;
   logic        ok;

   always_comb begin
      give_over  = req_word.give_bytes > held_ff;
      retained   = held_ff - req_word.give_bytes;
      room       = limit_ff - retained;
      fits       = !give_over && !(retained > limit_ff) && !(req_word.want_bytes > room);
      held_alloc = retained + req_word.want_bytes;
      bytes_sum  = {1'b0, bytes_ff} + {1'b0, req_word.want_bytes};

      passes_in = passes_ff;
      tokens_in = tokens_ff;
      held_in   = held_ff;
      peak_in   = peak_ff;
      allocs_in = allocs_ff;
      bytes_in  = bytes_ff;
      spent_in  = spent_ff;
      limit_in  = limit_ff;
      ok        = 1'b1;

      case (op_type'(req_word.operation))
         OP_INIT: begin
            passes_in = '0;
            tokens_in = '0;
            held_in   = '0;
            peak_in   = '0;
            allocs_in = '0;
            bytes_in  = '0;
            spent_in  = 1'b0;
            limit_in  = limit_candidate;
         end
         OP_PASS: begin
            if (passes_ff >= pass_limit) begin
               ok = 1'b0;
            end else begin
               passes_in = passes_ff + 16'd1;
            end
         end
         OP_TOKEN: begin
            if (tokens_ff >= token_limit) begin
               ok = 1'b0;
            end else begin
               tokens_in = tokens_ff + 32'd1;
            end
         end
         OP_FITS: begin
            ok = fits;
         end
         OP_RECORD: begin
            ok = fits;
            if (fits) begin
               held_in = held_alloc;
               if (held_alloc > peak_ff) begin
                  peak_in = held_alloc;
               end
               if (allocs_ff != '1) begin
                  allocs_in = allocs_ff + 32'd1;
               end
               bytes_in = bytes_sum[32] ? '1 : bytes_sum[31:0];
            end
         end
         OP_RELEASE: begin
            held_in = give_over ? '0 : retained;
         end
         OP_EXHAUST: begin
            spent_in = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      if (!ok && op_type'(req_word.operation) != OP_UNUSED) begin
         spent_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         passes_ff <= '0;
         tokens_ff <= '0;
         held_ff   <= '0;
         peak_ff   <= '0;
         allocs_ff <= '0;
         bytes_ff  <= '0;
         spent_ff  <= 1'b0;
         limit_ff  <= '0;
      end else if (fire) begin
         passes_ff <= passes_in;
         tokens_ff <= tokens_in;
         held_ff   <= held_in;
         peak_ff   <= peak_in;
         allocs_ff <= allocs_in;
         bytes_ff  <= bytes_in;
         spent_ff  <= spent_in;
         limit_ff  <= limit_in;
      end
   end

   always_comb begin
      rsp_word.accepted         = ok;
      rsp_word.pass_count       = passes_in;
      rsp_word.token_count      = tokens_in;
      rsp_word.allocation_count = allocs_in;
      rsp_word.allocation_total = bytes_in;
      rsp_word.peak_workspace   = peak_in;
      rsp_word.exhausted        = spent_in;
   end

endmodule

// ===== sv/resource_budget_tracker.sv =====
// A request word waits in the input register and its response in the response register.
// Throughput: one word per cycle while rsp_stall is low; the two registers form a
// two-stage pipe, and the accounting state updates as the response register loads.
// Reset is synchronous and active high; it clears the counters, the exhausted
// flag and the workspace limit, and returns the configuration to its defaults.
module resource_budget_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_give_bytes,
   input  logic [31:0] req_want_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [15:0] rsp_pass_count,
   output logic [31:0] rsp_token_count,
   output logic [31:0] rsp_allocation_count,
   output logic [31:0] rsp_allocation_total,
   output logic [31:0] rsp_peak_workspace,
   output logic        rsp_exhausted,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import rbt_pkg::*;

   logic [15:0]  pass_limit_ff;
   logic [31:0]  token_limit_ff;
   logic [31:0]  workspace_cap_ff;
   logic [31:0]  workspace_floor_ff;
   logic [7:0]   size_multiplier_ff;
   logic [31:0]  text_length_ff;

   logic         req_valid_ff;
   req_word_type req_word_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;
   logic [31:0]  limit_candidate;
   logic         advance;
   logic         fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_limit_ff      <= PASS_LIMIT_RESET;
         token_limit_ff     <= TOKEN_LIMIT_RESET;
         workspace_cap_ff   <= WORKSPACE_CAP_RESET;
         workspace_floor_ff <= WORKSPACE_FLOOR_RESET;
         size_multiplier_ff <= SIZE_MULTIPLIER_RESET;
         text_length_ff     <= TEXT_LENGTH_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_PASS_LIMIT:      pass_limit_ff      <= csr_data[15:0];
            CSR_TOKEN_LIMIT:     token_limit_ff     <= csr_data;
            CSR_WORKSPACE_CAP:   workspace_cap_ff   <= csr_data;
            CSR_WORKSPACE_FLOOR: workspace_floor_ff <= csr_data;
            CSR_SIZE_MULTIPLIER: size_multiplier_ff <= csr_data[7:0];
            CSR_TEXT_LENGTH:     text_length_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   rbt_limit u_limit (
      .clock           (clock),
      .text_length     (text_length_ff),
      .size_multiplier (size_multiplier_ff),
      .workspace_floor (workspace_floor_ff),
      .workspace_cap   (workspace_cap_ff),
      .limit           (limit_candidate)
   );

   // The response register frees up when it is empty or being drained.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_word_ff.operation  <= req_operation;
         req_word_ff.give_bytes <= req_give_bytes;
         req_word_ff.want_bytes <= req_want_bytes;
      end
   end

   rbt_core u_core (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .req_word        (req_word_ff),
      .pass_limit      (pass_limit_ff),
      .token_limit     (token_limit_ff),
      .limit_candidate (limit_candidate),
      .rsp_word        (rsp_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_accepted         = rsp_word_ff.accepted;
   assign rsp_pass_count       = rsp_word_ff.pass_count;
   assign rsp_token_count      = rsp_word_ff.token_count;
   assign rsp_allocation_count = rsp_word_ff.allocation_count;
   assign rsp_allocation_total = rsp_word_ff.allocation_total;
   assign rsp_peak_workspace   = rsp_word_ff.peak_workspace;
   assign rsp_exhausted        = rsp_word_ff.exhausted;

endmodule

// ===== dv/resource_budget_tracker_tb.sv =====
`timescale 1ns / 1ps

module resource_budget_tracker_tb;
   import rbt_pkg::*;

   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned ITEMS_PER_PHASE = 225;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   typedef enum logic [1:0] {ROW_EVENT, ROW_CHECKED, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   code;
      logic [31:0]  give_bytes;
      logic [31:0]  want_bytes;
      rsp_word_type want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_operation = '0;
   logic [31:0] req_give_bytes = '0;
   logic [31:0] req_want_bytes = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_accepted;
   logic [15:0] rsp_pass_count;
   logic [31:0] rsp_token_count;
   logic [31:0] rsp_allocation_count;
   logic [31:0] rsp_allocation_total;
   logic [31:0] rsp_peak_workspace;
   logic        rsp_exhausted;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // Expected word for a directed row whose result is typed in by hand.
   logic         row_typed = 1'b0;
   rsp_word_type row_want = '0;

   // Register copies and accounting state of the budget predictor.
   logic [15:0] lim_passes = PASS_LIMIT_RESET;
   logic [31:0] lim_tokens = TOKEN_LIMIT_RESET;
   logic [31:0] ws_cap = WORKSPACE_CAP_RESET;
   logic [31:0] ws_floor = WORKSPACE_FLOOR_RESET;
   logic [7:0]  ws_mult = SIZE_MULTIPLIER_RESET;
   logic [31:0] text_length = TEXT_LENGTH_RESET;
   logic [15:0] pass_tally = '0;
   logic [31:0] token_tally = '0;
   logic [31:0] held_bytes = '0;
   logic [31:0] peak_bytes = '0;
   logic [31:0] alloc_tally = '0;
   logic [31:0] byte_tally = '0;
   logic        budget_blown = 1'b0;
   logic [31:0] ws_limit = '0;

   rsp_word_type expected_words[$];
   plan_row_type directed_plan [0:33];

   int unsigned words_in = 0;
   int unsigned words_out = 0;
   int unsigned refusals = 0;
   int unsigned reg_writes = 0;
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   int unsigned burst_left = 0;
   int unsigned stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   resource_budget_tracker u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_give_bytes       (req_give_bytes),
      .req_want_bytes       (req_want_bytes),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_accepted         (rsp_accepted),
      .rsp_pass_count       (rsp_pass_count),
      .rsp_token_count      (rsp_token_count),
      .rsp_allocation_count (rsp_allocation_count),
      .rsp_allocation_total (rsp_allocation_total),
      .rsp_peak_workspace   (rsp_peak_workspace),
      .rsp_exhausted        (rsp_exhausted),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic realloc_fits(input logic [31:0] give, input logic [31:0] want_b);
      logic [31:0] retained;
      if (give > held_bytes) begin
         return 1'b0;
      end
      retained = held_bytes - give;
      if (retained > ws_limit) begin
         return 1'b0;
      end
      return want_b <= ws_limit - retained;
   endfunction

   task automatic account(input logic [2:0] op, input logic [31:0] give,
                          input logic [31:0] want_b, output rsp_word_type word);
      logic        ok;
      logic [31:0] kept;
      logic [39:0] product;
      ok = 1'b1;
      kept = held_bytes - give;
      case (op)
         OP_INIT: begin
            pass_tally = '0;
            token_tally = '0;
            held_bytes = '0;
            peak_bytes = '0;
            alloc_tally = '0;
            byte_tally = '0;
            budget_blown = 1'b0;
            product = {8'd0, text_length} * ws_mult;
            if (product[39:32] != 8'd0) begin
               ws_limit = ws_cap;
            end else begin
               ws_limit = (product[31:0] < ws_floor) ? ws_floor : product[31:0];
               if (ws_limit > ws_cap) begin
                  ws_limit = ws_cap;
               end
            end
         end
         OP_PASS: begin
            if (pass_tally >= lim_passes) ok = 1'b0;
            else pass_tally = pass_tally + 16'd1;
         end
         OP_TOKEN: begin
            if (token_tally >= lim_tokens) ok = 1'b0;
            else token_tally = token_tally + 32'd1;
         end
         OP_FITS: begin
            ok = realloc_fits(give, want_b);
         end
         OP_RECORD: begin
            ok = realloc_fits(give, want_b);
            if (ok) begin
               held_bytes = kept + want_b;
               if (held_bytes > peak_bytes) peak_bytes = held_bytes;
               if (alloc_tally != 32'hFFFF_FFFF) alloc_tally = alloc_tally + 32'd1;
               if (want_b > 32'hFFFF_FFFF - byte_tally) byte_tally = 32'hFFFF_FFFF;
               else byte_tally = byte_tally + want_b;
            end
         end
         OP_RELEASE: begin
            held_bytes = (give > held_bytes) ? 32'd0 : held_bytes - give;
         end
         OP_EXHAUST: begin
            budget_blown = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      if (!ok && op != OP_UNUSED) begin
         budget_blown = 1'b1;
      end
      if (!ok) begin
         refusals++;
      end
      word = '{ok, pass_tally, token_tally, alloc_tally, byte_tally, peak_bytes, budget_blown};
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string field, input logic [31:0] seen,
                                input logic [31:0] wanted);
      if (seen !== wanted) begin
         report_mismatch($sformatf("word %0d %s: got 0x%0h, expected 0x%0h",
                                   words_out, field, seen, wanted));
      end
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_word_type predicted;
      rsp_word_type oldest;
      logic         progress;
      if (!reset) begin
         progress = csr_write_en;
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            words_out++;
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("word %0d arrived with nothing expected", words_out));
            end else begin
               oldest = expected_words.pop_front();
               compare_field("accepted", 32'(rsp_accepted), 32'(oldest.accepted));
               compare_field("pass_count", 32'(rsp_pass_count), 32'(oldest.pass_count));
               compare_field("token_count", rsp_token_count, oldest.token_count);
               compare_field("allocation_count", rsp_allocation_count,
                             oldest.allocation_count);
               compare_field("allocation_total", rsp_allocation_total,
                             oldest.allocation_total);
               compare_field("peak_workspace", rsp_peak_workspace, oldest.peak_workspace);
               compare_field("exhausted", 32'(rsp_exhausted), 32'(oldest.exhausted));
            end
         end
         if (req_valid && !req_stall) begin
            progress = 1'b1;
            account(req_operation, req_give_bytes, req_want_bytes, predicted);
            expected_words.push_back(row_typed ? row_want : predicted);
            words_in <= words_in + 1;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles, %0d still expected",
                     idle_cycles, expected_words.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 150);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_left[2];
      endcase
   end

   task automatic send_word(input logic [2:0] op, input logic [31:0] give,
                            input logic [31:0] want_b, input logic typed,
                            input rsp_word_type typed_word);
      int unsigned gap;
      int unsigned start;
      csr_write_en <= 1'b0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            if (req_valid) req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_operation <= op;
      req_give_bytes <= give;
      req_want_bytes <= want_b;
      row_typed <= typed;
      row_want <= typed_word;
      start = words_in;
      do @(negedge clock); while (words_in == start);
   endtask

   task automatic drain_pending();
      if (req_valid) req_valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      case (idx)
         CSR_PASS_LIMIT: lim_passes = data[15:0];
         CSR_TOKEN_LIMIT: lim_tokens = data;
         CSR_WORKSPACE_CAP: ws_cap = data;
         CSR_WORKSPACE_FLOOR: ws_floor = data;
         CSR_SIZE_MULTIPLIER: ws_mult = data[7:0];
         CSR_TEXT_LENGTH: text_length = data;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_bytes(input logic [31:0] bound);
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return bound;
         2: return bound + 32'd1;
         3: return 32'hFFFF_FFFF;
         4: return $urandom;
         default: return $urandom_range(0, bound);
      endcase
   endfunction

   initial begin : stimulus
      int unsigned phase;
      int unsigned n;
      int unsigned pick;
      logic [2:0]  op;
      logic [31:0] give;
      logic [31:0] want_b;
      logic [15:0] set_passes;
      logic [31:0] set_tokens;
      logic [31:0] set_cap;
      logic [31:0] set_floor;
      logic [7:0]  set_mult;
      logic [31:0] set_length;

      directed_plan = '{
         '{ROW_CHECKED, OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '{0, 0, 0, 0, 0, 0, 0}},
         '{ROW_CHECKED, OP_FITS, 0, 0, '{1, 0, 0, 0, 0, 0, 0}},
         '{ROW_CHECKED, OP_RECORD, 0, 1, '{0, 0, 0, 0, 0, 0, 1}},
         '{ROW_CHECKED, OP_INIT, 0, 0, '{1, 0, 0, 0, 0, 0, 0}},
         '{ROW_CHECKED, OP_PASS, 0, 0, '{1, 1, 0, 0, 0, 0, 0}},
         '{ROW_CHECKED, OP_TOKEN, 0, 0, '{1, 1, 1, 0, 0, 0, 0}},
         '{ROW_CHECKED, OP_RECORD, 0, 4096, '{1, 1, 1, 1, 4096, 4096, 0}},
         '{ROW_EVENT, OP_FITS, 0, 1, '0},
         '{ROW_EVENT, OP_RECORD, 4097, 0, '0},
         '{ROW_EVENT, OP_RECORD, 4096, 100, '0},
         '{ROW_EVENT, OP_RELEASE, 32'hFFFF_FFFF, 0, '0},
         '{ROW_EVENT, OP_EXHAUST, 0, 0, '0},
         '{ROW_WRITE, CSR_PASS_LIMIT, 0, 0, '0},
         '{ROW_WRITE, CSR_TOKEN_LIMIT, 0, 0, '0},
         '{ROW_CHECKED, OP_INIT, 0, 0, '{1, 0, 0, 0, 0, 0, 0}},
         '{ROW_CHECKED, OP_PASS, 0, 0, '{0, 0, 0, 0, 0, 0, 1}},
         '{ROW_CHECKED, OP_TOKEN, 0, 0, '{0, 0, 0, 0, 0, 0, 1}},
         '{ROW_WRITE, CSR_WORKSPACE_FLOOR, 0, 100, '0},
         '{ROW_WRITE, CSR_WORKSPACE_CAP, 0, 50, '0},
         '{ROW_WRITE, CSR_SIZE_MULTIPLIER, 0, 0, '0},
         '{ROW_WRITE, CSR_TEXT_LENGTH, 0, 1000, '0},
         '{ROW_EVENT, OP_INIT, 0, 0, '0},
         '{ROW_EVENT, OP_RECORD, 0, 50, '0},
         '{ROW_EVENT, OP_RECORD, 0, 1, '0},
         '{ROW_WRITE, CSR_SIZE_MULTIPLIER, 0, 255, '0},
         '{ROW_WRITE, CSR_TEXT_LENGTH, 0, 32'hFFFF_FFFF, '0},
         '{ROW_WRITE, CSR_WORKSPACE_CAP, 0, 32'hFFFF_FFFF, '0},
         '{ROW_WRITE, CSR_WORKSPACE_FLOOR, 0, 0, '0},
         '{ROW_EVENT, OP_INIT, 0, 0, '0},
         '{ROW_EVENT, OP_RECORD, 0, 32'hFFFF_FFFF, '0},
         '{ROW_EVENT, OP_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0},
         '{ROW_WRITE, CSR_SPARE_LO, 0, 32'h5A5A_5A5A, '0},
         '{ROW_WRITE, CSR_SPARE_HI, 0, 32'hFFFF_FFFF, '0},
         '{ROW_EVENT, OP_INIT, 0, 0, '0}
      };

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_WRITE) begin
            drain_pending();
            write_reg(directed_plan[i].code, directed_plan[i].want_bytes);
         end else begin
            send_word(directed_plan[i].code, directed_plan[i].give_bytes,
                      directed_plan[i].want_bytes, directed_plan[i].kind == ROW_CHECKED,
                      directed_plan[i].want);
         end
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_pending();
         set_passes = 16'($urandom_range(0, 24));
         set_tokens = $urandom_range(0, 40);
         set_mult = 8'($urandom_range(1, 255));
         set_length = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4096);
         set_floor = $urandom_range(0, 8192);
         set_cap = $urandom_range(0, 32'h0020_0000);
         case (phase)
            0: begin
               set_passes = '0;
               set_tokens = '0;
               set_cap = '0;
               set_floor = '0;
               set_mult = 8'd1;
               set_length = '0;
            end
            1: begin
               set_passes = '1;
               set_tokens = '1;
               set_cap = '1;
               set_floor = '1;
               set_mult = 8'd255;
               set_length = '1;
            end
            2: begin
               set_cap = $urandom_range(0, 4000);
               set_floor = $urandom_range(4001, 200000);
            end
            3: begin
               set_mult = '0;
            end
            default: ;
         endcase
         write_reg(CSR_PASS_LIMIT, {16'($urandom), set_passes});
         write_reg(CSR_TOKEN_LIMIT, set_tokens);
         write_reg(CSR_WORKSPACE_CAP, set_cap);
         write_reg(CSR_WORKSPACE_FLOOR, set_floor);
         write_reg(CSR_SIZE_MULTIPLIER, {24'($urandom), set_mult});
         write_reg(CSR_TEXT_LENGTH, set_length);
         write_reg($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom);
         send_word(OP_INIT, $urandom, $urandom, 1'b0, '0);

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == ITEMS_PER_PHASE / 2) begin
               drain_pending();
            end
            pick = $urandom_range(0, 99);
            if (pick < 4) op = OP_INIT;
            else if (pick < 18) op = OP_PASS;
            else if (pick < 32) op = OP_TOKEN;
            else if (pick < 46) op = OP_FITS;
            else if (pick < 76) op = OP_RECORD;
            else if (pick < 92) op = OP_RELEASE;
            else if (pick < 97) op = OP_EXHAUST;
            else op = OP_UNUSED;
            give = $urandom;
            want_b = $urandom;
            if (op == OP_FITS || op == OP_RECORD || op == OP_RELEASE) begin
               give = pick_bytes(held_bytes);
               if (give <= held_bytes && held_bytes - give <= ws_limit) begin
                  want_b = pick_bytes(ws_limit - (held_bytes - give));
               end
            end
            send_word(op, give, want_b, 1'b0, '0);
         end
      end

      drain_pending();
      repeat (8) @(negedge clock);
      $display("Run covered %0d request words and %0d response words, %0d of them refused.",
               words_in, words_out, refusals);
      $display("Registers written %0d times over %0d random settings and the directed table.",
               reg_writes, RANDOM_PHASES);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/rbt_pkg.sv
sv/rbt_limit.sv
sv/rbt_core.sv
sv/resource_budget_tracker.sv
dv/resource_budget_tracker_tb.sv
